// ===== hdl/polymorphic_field_cache_update_defines.svh =====
// Assertion macros shared by the checker of the field cache update block.
`ifndef POLYMORPHIC_FIELD_CACHE_UPDATE_DEFINES_SVH
`define POLYMORPHIC_FIELD_CACHE_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PFCU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PFCU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pfcu_pkg.sv =====
// Package with mode codes and result field layout of the field cache update block.
package pfcu_pkg;

  // Cache mode codes as reported on the result stream
  localparam logic [1:0] MODE_UNINIT = 2'd0;
  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_POLY   = 2'd2;
  localparam logic [1:0] MODE_MEGA   = 2'd3;

  // Fixed field widths
  localparam int SYM_W   = 31;
  localparam int MODE_W  = 2;
  localparam int USED_W  = 3;
  localparam int TOUCH_W = 2;
  localparam int MISS_W  = 32;

  // Result tdata layout, lowest bit first
  localparam int MODE_LO  = 0;
  localparam int USED_LO  = MODE_LO + MODE_W;
  localparam int TOUCH_LO = USED_LO + USED_W;
  localparam int WR_LO    = TOUCH_LO + TOUCH_W;
  localparam int MISS_LO  = WR_LO + 1;
  localparam int OUT_W    = ((MISS_LO + MISS_W + 7) / 8) * 8;

  localparam logic [MISS_W-1:0] MISS_MAX = '1;

endpackage

// ===== hdl/polymorphic_field_cache_update.sv =====
// Polymorphic inline cache update path: an input register, the way compare and a result register.
// Accepts one update item per clock whenever the result side takes items; each item is held
// in the input register and its result in the result register. All WAYS stored class tags
// are compared in parallel between those two registers; a stalled result register holds
// the input register, and the input side stalls once both are full. No clearing pass is
// needed after reset.
module polymorphic_field_cache_update #(
  parameter int WAYS        = 4,
  parameter int TAG_BITS    = 32,
  parameter int OFFSET_BITS = 16,
  localparam int IN_W = ((TAG_BITS + OFFSET_BITS + pfcu_pkg::SYM_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // s_tdata: class_tag, field_offset, symbol_id, zero pad
  input  logic [IN_W-1:0]            s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // m_tdata: cache_mode, ways_used, way_touched, way_was_written, misses_so_far
  output logic [pfcu_pkg::OUT_W-1:0] m_tdata,
  // m_tuser: item_ignored
  output logic                       m_tuser
);
  import pfcu_pkg::*;

  localparam int CW = $clog2(WAYS + 1);
  localparam int IW = $clog2(WAYS);

  // Input register
  logic                   in_vld;
  logic [TAG_BITS-1:0]    in_tag;
  logic [OFFSET_BITS-1:0] in_off;
  logic [SYM_W-1:0]       in_sym;

  // Cache state
  logic [1:0]             mode;
  logic [CW-1:0]          count;
  logic [TAG_BITS-1:0]    way_class  [WAYS];
  logic [OFFSET_BITS-1:0] way_offset [WAYS];
  logic [SYM_W-1:0]       sym_held;
  logic                   sym_held_valid;
  logic [MISS_W-1:0]      miss;

  // Update logic
  logic                   advance;
  logic                   ignored;
  logic                   sym_clear;
  logic [1:0]             eff_mode;
  logic [CW-1:0]          eff_count;
  logic [MISS_W-1:0]      eff_miss;
  logic [WAYS-1:0]        hit_vec;
  logic [IW-1:0]          hit_idx;
  logic [1:0]             mode_next;
  logic [CW-1:0]          count_next;
  logic [MISS_W-1:0]      miss_next;
  logic                   wr_en;
  logic [IW-1:0]          wr_idx;
  logic [OUT_W-1:0]       res_data;

  assign advance  = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || !m_tvalid || m_tready;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_tag <= s_tdata[TAG_BITS-1:0];
      in_off <= s_tdata[TAG_BITS +: OFFSET_BITS];
      in_sym <= s_tdata[TAG_BITS + OFFSET_BITS +: SYM_W];
    end
  end

  // Compare all valid ways against the tag
  always_comb begin
    ignored   = (in_tag == '0);
    sym_clear = sym_held_valid && (sym_held != in_sym);
    eff_mode  = sym_clear ? MODE_UNINIT : mode;
    eff_count = sym_clear ? '0 : count;
    eff_miss  = sym_clear ? '0 : miss;
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = (CW'(i) < eff_count) && (way_class[i] == in_tag);
    end
    hit_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IW'(i);
      end
    end
  end

  // Decide mode, fill and miss count
  always_comb begin
    mode_next  = eff_mode;
    count_next = eff_count;
    miss_next  = eff_miss;
    wr_en      = 1'b0;
    wr_idx     = '0;
    if (eff_mode == MODE_MEGA) begin
      miss_next = (eff_miss == MISS_MAX) ? eff_miss : eff_miss + 1'b1;
    end else if (eff_mode == MODE_UNINIT) begin
      mode_next  = MODE_MONO;
      count_next = CW'(1);
      wr_en      = 1'b1;
    end else if (hit_vec != '0) begin
      wr_en  = 1'b1;
      wr_idx = hit_idx;
    end else if (eff_count < CW'(WAYS)) begin
      mode_next  = MODE_POLY;
      count_next = eff_count + 1'b1;
      wr_en      = 1'b1;
      wr_idx     = eff_count[IW-1:0];
    end else begin
      mode_next = MODE_MEGA;
      miss_next = (eff_miss == MISS_MAX) ? eff_miss : eff_miss + 1'b1;
    end
  end

  // Commit state for a non-ignored item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_UNINIT;
      count          <= '0;
      miss           <= '0;
      sym_held       <= '0;
      sym_held_valid <= 1'b0;
    end else if (advance && !ignored) begin
      mode           <= mode_next;
      count          <= count_next;
      miss           <= miss_next;
      sym_held       <= in_sym;
      sym_held_valid <= 1'b1;
    end
  end

  // Fill or refresh one way
  always_ff @(posedge clk) begin
    if (advance && !ignored && wr_en) begin
      way_class[wr_idx]  <= in_tag;
      way_offset[wr_idx] <= in_off;
    end
  end

  // Pack the result fields
  always_comb begin
    res_data = '0;
    if (ignored) begin
      res_data[MODE_LO +: MODE_W] = mode;
      res_data[USED_LO +: USED_W] = USED_W'(count);
      res_data[MISS_LO +: MISS_W] = miss;
    end else begin
      res_data[MODE_LO +: MODE_W]   = mode_next;
      res_data[USED_LO +: USED_W]   = USED_W'(count_next);
      res_data[TOUCH_LO +: TOUCH_W] = TOUCH_W'(wr_idx);
      res_data[WR_LO]               = wr_en;
      res_data[MISS_LO +: MISS_W]   = miss_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_vld;
    end
    if (advance) begin
      m_tdata <= res_data;
      m_tuser <= ignored;
    end
  end

endmodule

// ===== hdl/pfcu_checker.sv =====
// Port-level checker for the field cache update block, with its bind.
`include "polymorphic_field_cache_update_defines.svh"

module pfcu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [pfcu_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tuser
);
  import pfcu_pkg::*;

  // Hold a stalled result item
  `PFCU_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

  // An ignored item touches no way
  `PFCU_ASSERT_IMP(a_ign, m_tvalid && m_tuser, !m_tdata[WR_LO] && (m_tdata[TOUCH_LO +: TOUCH_W] == '0), "ignored item reports a way write")

  // Megamorphic updates write no way
  `PFCU_ASSERT_IMP(a_mega, m_tvalid && (m_tdata[MODE_LO +: MODE_W] == MODE_MEGA), !m_tdata[WR_LO], "way written in megamorphic mode")

  // Uninitialized mode has no ways and no misses and is reported only for ignored items
  `PFCU_ASSERT_IMP(a_uninit, m_tvalid && (m_tdata[MODE_LO +: MODE_W] == MODE_UNINIT), (m_tdata[USED_LO +: USED_W] == '0) && (m_tdata[MISS_LO +: MISS_W] == '0) && m_tuser, "uninitialized mode with state")

endmodule

bind polymorphic_field_cache_update pfcu_checker u_pfcu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
